### hw/rtl/vh_pkg.sv
// value histogram package: shared types, field widths and parameter defaults
// no dependencies; imported by vh_cell and value_histogram_unit
package vh_pkg;

	// fixed field widths of the transaction ports
	localparam int SAMPLE_W    = 8;
	localparam int BIN_COUNT_W = 16;

	// parameter defaults
	localparam int LOWEST_SAMPLE_DEF  = -100;
	localparam int HIGHEST_SAMPLE_DEF = 100;
	localparam int COUNT_BITS_DEF     = 16;

	// function codes of an input transaction
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// control part of the token that walks down the cell row
	typedef struct packed {
		logic vld;   // token carries a transaction
		logic rd;    // readout of one bin
		logic add;   // add of an in-range sample
		logic last;  // readout of the final bin
	} ctl_t;

endpackage

### hw/rtl/value_histogram_unit.sv
// value histogram top level: head logic, row of bin cells and result register
// depends on vh_pkg and vh_cell
// path from transaction to result: one cell per bin (default 201 cells), then the
// result register; throughput one transaction per cycle while result_stall does not
// hold the row, set by the token advancing one cell per cycle along the row.
// reset clears every bin counter and the scan pointer at once; no clearing pass.
module value_histogram_unit #(
	parameter int LOWEST_SAMPLE  = vh_pkg::LOWEST_SAMPLE_DEF,
	parameter int HIGHEST_SAMPLE = vh_pkg::HIGHEST_SAMPLE_DEF,
	parameter int COUNT_BITS     = vh_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic                           func,
	input  logic signed [vh_pkg::SAMPLE_W-1:0]    sample_value,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [vh_pkg::SAMPLE_W-1:0]    bin_value,
	output logic [vh_pkg::BIN_COUNT_W-1:0] bin_count,
	output logic                           last_bin
);
	import vh_pkg::*;

	localparam int BIN_TOTAL = HIGHEST_SAMPLE - LOWEST_SAMPLE + 1;
	localparam int IDX_W     = $clog2(BIN_TOTAL);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_TOTAL - 1);

	logic                   adv;
	logic                   accept;
	logic [IDX_W-1:0]       ptr_q;
	logic signed [31:0]     samp_ext;
	logic                   in_range;
	logic [31:0]            samp_off;
	ctl_t                   head_ctl;
	logic [IDX_W-1:0]       head_idx;
	logic                   emit;
	logic [31:0]            value_sum;

	ctl_t                   link_ctl [BIN_TOTAL+1];
	logic [IDX_W-1:0]       link_idx [BIN_TOTAL+1];
	logic [BIN_COUNT_W-1:0] link_cnt [BIN_TOTAL+1];

	logic                   res_vld_q;
	logic [SAMPLE_W-1:0]    res_value_q;
	logic [BIN_COUNT_W-1:0] res_cnt_q;
	logic                   res_last_q;

	// whole row moves when the result register can take a transaction
	assign adv          = !res_vld_q || !result_stall;
	assign sample_stall = !adv;
	assign accept       = sample_valid && adv;

	// range check and bin index of an incoming sample
	assign samp_ext = {{(32-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
	assign in_range = (samp_ext >= LOWEST_SAMPLE) && (samp_ext <= HIGHEST_SAMPLE);
	assign samp_off = samp_ext - LOWEST_SAMPLE;

	// token formed at the head of the row
	always_comb begin
		head_ctl      = '0;
		head_ctl.vld  = accept;
		head_ctl.rd   = (func == FUNC_READ);
		head_ctl.add  = (func == FUNC_ADD) && in_range;
		head_ctl.last = (func == FUNC_READ) && (ptr_q == LAST_IDX);
		head_idx      = (func == FUNC_READ) ? ptr_q : samp_off[IDX_W-1:0];
	end

	// scan pointer steps one bin per readout transaction, wraps after the final bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (accept && (func == FUNC_READ)) begin
			if (ptr_q == LAST_IDX) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign link_ctl[0] = head_ctl;
	assign link_idx[0] = head_idx;
	assign link_cnt[0] = '0;

	// row of bin cells
	for (genvar g = 0; g < BIN_TOTAL; g++) begin : g_cell
		vh_cell #(
			.IDX_W      (IDX_W),
			.COUNT_BITS (COUNT_BITS),
			.CELL_IDX   (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (link_ctl[g]),
			.idx_in  (link_idx[g]),
			.cnt_in  (link_cnt[g]),
			.ctl_out (link_ctl[g+1]),
			.idx_out (link_idx[g+1]),
			.cnt_out (link_cnt[g+1])
		);
	end

	// a readout leaves a result for a nonzero bin or the final bin
	assign emit = link_ctl[BIN_TOTAL].vld && link_ctl[BIN_TOTAL].rd
		&& ((link_cnt[BIN_TOTAL] != '0) || link_ctl[BIN_TOTAL].last);
	assign value_sum = 32'(link_idx[BIN_TOTAL]) + LOWEST_SAMPLE;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_value_q <= value_sum[SAMPLE_W-1:0];
			res_cnt_q   <= link_cnt[BIN_TOTAL];
			res_last_q  <= link_ctl[BIN_TOTAL].last;
		end
	end

	assign result_valid = res_vld_q;
	assign bin_value    = res_value_q;
	assign bin_count    = res_cnt_q;
	assign last_bin     = res_last_q;

endmodule

### hw/rtl/vh_cell.sv
// one histogram cell: holds the counter of a single bin and passes the token on
// depends on vh_pkg (ctl_t, BIN_COUNT_W)
module vh_cell #(
	parameter int IDX_W      = 8,
	parameter int COUNT_BITS = vh_pkg::COUNT_BITS_DEF,
	parameter int CELL_IDX   = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  vh_pkg::ctl_t                   ctl_in,
	input  logic [IDX_W-1:0]               idx_in,
	input  logic [vh_pkg::BIN_COUNT_W-1:0] cnt_in,
	output vh_pkg::ctl_t                   ctl_out,
	output logic [IDX_W-1:0]               idx_out,
	output logic [vh_pkg::BIN_COUNT_W-1:0] cnt_out
);
	import vh_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [COUNT_BITS-1:0]  count_q;
	ctl_t                   ctl_q;
	logic [IDX_W-1:0]       idx_q;
	logic [BIN_COUNT_W-1:0] cnt_q;
	logic                   hit;
	logic [31:0]            count_wide;

	// token addresses this bin
	assign hit        = ctl_in.vld && (idx_in == MY_IDX);
	assign count_wide = 32'(count_q);

	// bin counter: saturating add, cleared when read out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv && hit) begin
			if (ctl_in.rd) begin
				count_q <= '0;
			end else if (ctl_in.add && (count_q != {COUNT_BITS{1'b1}})) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// token control stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	// token payload stage, picks up the count on a readout hit
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_q <= idx_in;
			if (hit && ctl_in.rd) begin
				cnt_q <= count_wide[BIN_COUNT_W-1:0];
			end else begin
				cnt_q <= cnt_in;
			end
		end
	end

	assign ctl_out = ctl_q;
	assign idx_out = idx_q;
	assign cnt_out = cnt_q;

endmodule
